// ----- hw/rtl/temperature_limit_alarm_display_unit_defines.svh -----
// assertion macros for the temperature limit alarm display unit
// included by files that carry concurrent checks; no other dependencies
`ifndef TEMPERATURE_LIMIT_ALARM_DISPLAY_UNIT_DEFINES_SVH
`define TEMPERATURE_LIMIT_ALARM_DISPLAY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLAD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlad check failed");
// next-cycle implication
`define TLAD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlad check failed");
`else
`define TLAD_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLAD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/tlad_pkg.sv -----
// shared types, codes and segment tables for the temperature alarm display
// no dependencies
package tlad_pkg;

   // input mode codes
   localparam logic [2:0] MODE_SAMPLE = 3'd0;
   localparam logic [2:0] MODE_UP     = 3'd1;
   localparam logic [2:0] MODE_DOWN   = 3'd2;
   localparam logic [2:0] MODE_SELECT = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;

   // display pages
   localparam logic [1:0] PAGE_TEMP  = 2'd0;
   localparam logic [1:0] PAGE_UPPER = 2'd1;
   localparam logic [1:0] PAGE_LOWER = 2'd2;

   localparam logic signed [8:0] UPPER_MAX = 9'sd125;
   localparam logic signed [8:0] LOWER_MIN = -9'sd55;
   localparam logic signed [7:0] UPPER_RESET = 8'sd35;
   localparam logic signed [7:0] LOWER_RESET = 8'sd16;

   localparam logic [7:0] SEG_BLANK = 8'hff;
   localparam logic [7:0] SEG_MINUS = 8'hbf;
   localparam logic [7:0] SEG_H     = 8'h89;
   localparam logic [7:0] SEG_L     = 8'hc7;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SAMPLE,
      OP_UP,
      OP_DOWN,
      OP_SELECT,
      OP_TICK
   } op_type;

   // one classified event waiting in the queue
   typedef struct packed {
      op_type             op;
      logic signed [11:0] reading;
      logic signed [8:0]  whole;    // reading / 10, truncated toward zero
   } entry_type;

   // state after one event, handed to the display pipeline
   typedef struct packed {
      logic [1:0]         page;
      logic signed [11:0] value;
      logic               high;
      logic               low;
      logic               buzzer;
   } snap_type;

   function automatic logic [7:0] seg_plain(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'hc0;
         4'd1: code = 8'hf9;
         4'd2: code = 8'ha4;
         4'd3: code = 8'hb0;
         4'd4: code = 8'h99;
         4'd5: code = 8'h92;
         4'd6: code = 8'h82;
         4'd7: code = 8'hf8;
         4'd8: code = 8'h80;
         4'd9: code = 8'h90;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

   // same digit with the decimal point lit
   function automatic logic [7:0] seg_point(input logic [3:0] digit);
      return seg_plain(digit) & 8'h7f;
   endfunction

endpackage

// ----- hw/rtl/tlad_front.sv -----
// front end: accepts events, classifies the mode, precomputes whole degrees
// depends on tlad_pkg
module tlad_front (
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2:0]             in_mode,
   input  logic signed [11:0]     in_temperature,
   output logic                   push_valid,
   input  logic                   push_ready,
   output tlad_pkg::entry_type    push_entry
);

   logic              neg;
   logic [11:0]       mag;
   logic [24:0]       prod;
   logic [7:0]        quot;
   tlad_pkg::op_type  op;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;

   always_comb begin
      case (in_mode)
         tlad_pkg::MODE_SAMPLE: op = tlad_pkg::OP_SAMPLE;
         tlad_pkg::MODE_UP:     op = tlad_pkg::OP_UP;
         tlad_pkg::MODE_DOWN:   op = tlad_pkg::OP_DOWN;
         tlad_pkg::MODE_SELECT: op = tlad_pkg::OP_SELECT;
         tlad_pkg::MODE_TICK:   op = tlad_pkg::OP_TICK;
         default:               op = tlad_pkg::OP_NONE;
      endcase
   end

   // |t| / 10 by reciprocal, exact for |t| <= 2048
   assign neg  = in_temperature[11];
   assign mag  = neg ? 12'(-in_temperature) : 12'(in_temperature);
   assign prod = {13'd0, mag} * 25'd6554;
   assign quot = prod[23:16];

   always_comb begin
      push_entry.op      = op;
      push_entry.reading = in_temperature;
      push_entry.whole   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   end

endmodule

// ----- hw/rtl/tlad_queue.sv -----
// short event queue between the front end and the state machine
// depends on tlad_pkg
module tlad_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tlad_pkg::entry_type    in_entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tlad_pkg::entry_type    out_entry
);

   localparam int PTR_WIDTH = (tlad_pkg::QUEUE_DEPTH > 1) ? $clog2(tlad_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(tlad_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(tlad_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(tlad_pkg::QUEUE_DEPTH);

   tlad_pkg::entry_type   mem_ff [tlad_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

// ----- hw/rtl/tlad_back.sv -----
// back end: limits, page, tick and buzzer state; emits a snapshot per event
// depends on tlad_pkg
module tlad_back #(
   parameter int TICKS_PER_WRAP = 100,
   parameter int BEEP_DIVIDER   = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tlad_pkg::entry_type    in_entry,
   output logic                   snap_valid,
   input  logic                   snap_ready,
   output tlad_pkg::snap_type     snap
);

   localparam int BEEP_WIDTH = (BEEP_DIVIDER > 1) ? $clog2(BEEP_DIVIDER) : 1;
   localparam logic [BEEP_WIDTH-1:0] BEEP_LAST = BEEP_WIDTH'(BEEP_DIVIDER - 1);

   logic signed [11:0]    reading_ff, reading_in;
   logic signed [8:0]     whole_ff, whole_in;
   logic signed [7:0]     upper_ff, upper_in;
   logic signed [7:0]     lower_ff, lower_in;
   logic [1:0]            page_ff, page_in;
   logic [6:0]            tick_ff, tick_in;
   logic [BEEP_WIDTH-1:0] phase_ff, phase_in;
   logic                  buzzer_ff, buzzer_in;
   logic                  snap_valid_ff, snap_valid_in;
   tlad_pkg::snap_type    snap_ff, snap_in;

   logic                  pop;
   logic signed [8:0]     upper_x, lower_x;
   logic [7:0]            tick_sum;
   logic                  wrap;
   logic                  alarm_now;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign pop        = in_valid && in_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   assign upper_x   = 9'(upper_ff);
   assign lower_x   = 9'(lower_ff);
   assign alarm_now = (whole_ff >= upper_x) || (whole_ff <= lower_x);
   assign tick_sum  = {1'b0, tick_ff} + 8'd1;
   assign wrap      = (tick_sum > 8'(TICKS_PER_WRAP));

   always_comb begin
      reading_in = reading_ff;
      whole_in   = whole_ff;
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      page_in    = page_ff;
      tick_in    = tick_ff;
      phase_in   = phase_ff;
      buzzer_in  = buzzer_ff;
      if (pop) begin
         case (in_entry.op)
            tlad_pkg::OP_SAMPLE: begin
               reading_in = in_entry.reading;
               whole_in   = in_entry.whole;
            end
            tlad_pkg::OP_UP: begin
               if (page_ff == tlad_pkg::PAGE_UPPER) begin
                  if (upper_x < tlad_pkg::UPPER_MAX) upper_in = upper_ff + 8'sd1;
               end else if (page_ff == tlad_pkg::PAGE_LOWER) begin
                  if (lower_x < upper_x - 9'sd1) lower_in = lower_ff + 8'sd1;
               end
            end
            tlad_pkg::OP_DOWN: begin
               if (page_ff == tlad_pkg::PAGE_UPPER) begin
                  if (upper_x > lower_x + 9'sd1) upper_in = upper_ff - 8'sd1;
               end else if (page_ff == tlad_pkg::PAGE_LOWER) begin
                  if (lower_x > tlad_pkg::LOWER_MIN) lower_in = lower_ff - 8'sd1;
               end
            end
            tlad_pkg::OP_SELECT: begin
               page_in = (page_ff == tlad_pkg::PAGE_LOWER) ? tlad_pkg::PAGE_TEMP
                                                           : page_ff + 2'd1;
            end
            tlad_pkg::OP_TICK: begin
               tick_in = wrap ? 7'd0 : tick_sum[6:0];
               // phase follows tick count modulo the beep divider
               if (wrap || phase_ff == BEEP_LAST) begin
                  phase_in = '0;
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
               if (phase_in == '0) begin
                  buzzer_in = alarm_now ? !buzzer_ff : 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      snap_in       = snap_ff;
      if (pop) begin
         snap_valid_in = 1'b1;
         snap_in.page  = page_in;
         case (page_in)
            tlad_pkg::PAGE_UPPER: snap_in.value = 12'(upper_in);
            tlad_pkg::PAGE_LOWER: snap_in.value = 12'(lower_in);
            default:              snap_in.value = reading_in;
         endcase
         snap_in.high   = (whole_in >= 9'(upper_in));
         snap_in.low    = (whole_in <= 9'(lower_in));
         snap_in.buzzer = buzzer_in;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff    <= '0;
         whole_ff      <= '0;
         upper_ff      <= tlad_pkg::UPPER_RESET;
         lower_ff      <= tlad_pkg::LOWER_RESET;
         page_ff       <= tlad_pkg::PAGE_TEMP;
         tick_ff       <= '0;
         phase_ff      <= '0;
         buzzer_ff     <= 1'b1;
         snap_valid_ff <= 1'b0;
      end else begin
         reading_ff    <= reading_in;
         whole_ff      <= whole_in;
         upper_ff      <= upper_in;
         lower_ff      <= lower_in;
         page_ff       <= page_in;
         tick_ff       <= tick_in;
         phase_ff      <= phase_in;
         buzzer_ff     <= buzzer_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

// ----- hw/rtl/tlad_display.sv -----
// display pipeline: digit split by reciprocal multiply, then segment coding
// depends on tlad_pkg
module tlad_display (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_valid,
   output logic                   snap_ready,
   input  tlad_pkg::snap_type     snap,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_seg_first,
   output logic [7:0]             out_seg_second,
   output logic [7:0]             out_seg_third,
   output logic [7:0]             out_seg_fourth,
   output logic                   out_high,
   output logic                   out_low,
   output logic                   out_buzzer,
   output logic [1:0]             out_page
);

   typedef struct packed {
      logic [1:0]  page;
      logic        neg;
      logic [11:0] mag;
      logic [7:0]  q10;
      logic [4:0]  q100;
      logic [1:0]  q1000;
      logic        gt999;
      logic        gt99;
      logic        ge10;
      logic        high;
      logic        low;
      logic        buzzer;
   } split_type;

   typedef struct packed {
      logic [7:0] seg_first;
      logic [7:0] seg_second;
      logic [7:0] seg_third;
      logic [7:0] seg_fourth;
      logic       high;
      logic       low;
      logic       buzzer;
      logic [1:0] page;
   } result_type;

   logic        s1_valid_ff, s1_valid_in;
   split_type   s1_ff, s1_in;
   logic        s2_valid_ff, s2_valid_in;
   result_type  s2_ff, s2_in;
   logic        s1_ready, s2_ready;

   logic        neg;
   logic [11:0] mag;
   logic [25:0] p10, p100, p1000;
   logic [11:0] units_w;
   logic [7:0]  tens_w;
   logic [4:0]  hund_w;
   logic [3:0]  units, tens, hund, thou;

   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign snap_ready = s1_ready;

   // stage 1: magnitude and quotients by 10, 100 and 1000, exact up to 2048
   assign neg   = snap.value[11];
   assign mag   = neg ? 12'(-snap.value) : 12'(snap.value);
   assign p10   = {14'd0, mag} * 26'd6554;
   assign p100  = {14'd0, mag} * 26'd5243;
   assign p1000 = {14'd0, mag} * 26'd8389;

   always_comb begin
      s1_in.page   = snap.page;
      s1_in.neg    = neg;
      s1_in.mag    = mag;
      s1_in.q10    = p10[23:16];
      s1_in.q100   = p100[23:19];
      s1_in.q1000  = p1000[24:23];
      s1_in.gt999  = (mag > 12'd999);
      s1_in.gt99   = (mag > 12'd99);
      s1_in.ge10   = (mag >= 12'd10);
      s1_in.high   = snap.high;
      s1_in.low    = snap.low;
      s1_in.buzzer = snap.buzzer;
      s1_valid_in  = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = snap_valid;
      end
   end

   // stage 2: decimal digits and segment codes
   assign units_w = s1_ff.mag - 12'(s1_ff.q10) * 12'd10;
   assign tens_w  = s1_ff.q10 - 8'(s1_ff.q100) * 8'd10;
   assign hund_w  = s1_ff.q100 - 5'(s1_ff.q1000) * 5'd10;
   assign units   = units_w[3:0];
   assign tens    = tens_w[3:0];
   assign hund    = hund_w[3:0];
   assign thou    = {2'b00, s1_ff.q1000};

   always_comb begin
      s2_in.high   = s1_ff.high;
      s2_in.low    = s1_ff.low;
      s2_in.buzzer = s1_ff.buzzer;
      s2_in.page   = s1_ff.page;
      s2_in.seg_fourth = tlad_pkg::seg_plain(units);
      if (s1_ff.page == tlad_pkg::PAGE_UPPER || s1_ff.page == tlad_pkg::PAGE_LOWER) begin
         s2_in.seg_first = (s1_ff.page == tlad_pkg::PAGE_UPPER) ? tlad_pkg::SEG_H
                                                                : tlad_pkg::SEG_L;
         if (s1_ff.neg) begin
            if (s1_ff.ge10) begin
               s2_in.seg_second = tlad_pkg::SEG_MINUS;
               s2_in.seg_third  = tlad_pkg::seg_plain(tens);
            end else begin
               s2_in.seg_second = tlad_pkg::SEG_BLANK;
               s2_in.seg_third  = tlad_pkg::SEG_MINUS;
            end
         end else if (s1_ff.gt99) begin
            s2_in.seg_second = tlad_pkg::seg_plain(hund);
            s2_in.seg_third  = tlad_pkg::seg_plain(tens);
         end else if (s1_ff.ge10) begin
            s2_in.seg_second = tlad_pkg::SEG_BLANK;
            s2_in.seg_third  = tlad_pkg::seg_plain(tens);
         end else begin
            s2_in.seg_second = tlad_pkg::SEG_BLANK;
            s2_in.seg_third  = tlad_pkg::SEG_BLANK;
         end
      end else begin
         s2_in.seg_third = tlad_pkg::seg_point(tens);
         if (s1_ff.neg) begin
            // minus moves right when the hundreds digit is zero
            if (hund == 4'd0) begin
               s2_in.seg_first  = tlad_pkg::SEG_BLANK;
               s2_in.seg_second = tlad_pkg::SEG_MINUS;
            end else begin
               s2_in.seg_first  = tlad_pkg::SEG_MINUS;
               s2_in.seg_second = tlad_pkg::seg_plain(hund);
            end
         end else begin
            s2_in.seg_first  = s1_ff.gt999 ? tlad_pkg::seg_plain(thou) : tlad_pkg::SEG_BLANK;
            s2_in.seg_second = s1_ff.gt99 ? tlad_pkg::seg_plain(hund) : tlad_pkg::SEG_BLANK;
         end
      end
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid      = s2_valid_ff;
   assign out_seg_first  = s2_ff.seg_first;
   assign out_seg_second = s2_ff.seg_second;
   assign out_seg_third  = s2_ff.seg_third;
   assign out_seg_fourth = s2_ff.seg_fourth;
   assign out_high       = s2_ff.high;
   assign out_low        = s2_ff.low;
   assign out_buzzer     = s2_ff.buzzer;
   assign out_page       = s2_ff.page;

endmodule

// ----- hw/rtl/temperature_limit_alarm_display_unit.sv -----
// top level of the temperature limit alarm with four-digit segment display
// depends on tlad_pkg, tlad_front, tlad_queue, tlad_back, tlad_display
//
//   port group | dir | carries
//   req_*      | in  | one event: mode and temperature sample
//   rsp_*      | out | four segment codes, alarms, buzzer level, page
//
// one event per cycle sustained while rsp_tready is high; rsp valid follows the req transfer
// through the queue register at the transfer, state update, digit split multiply, segment register
// reset sets all control state and empties the queue and pipeline; no clearing pass
// rsp_tready low holds the output register and backs up the two display
// stages and the state update; the two-entry queue then fills and drops req_tready
module temperature_limit_alarm_display_unit #(
   parameter int TICKS_PER_WRAP = 100,
   parameter int BEEP_DIVIDER   = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] temperature, [15:12] zero
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] segments_first, [15:8] segments_second,
                                    // [23:16] segments_third, [31:24] segments_fourth,
                                    // [32] high_alarm, [33] low_alarm, [34] buzzer_pin,
                                    // [39:35] zero
   output logic [1:0]  rsp_tuser    // [1:0] page_shown
);

`include "temperature_limit_alarm_display_unit_defines.svh"

   logic                 push_valid, push_ready;
   tlad_pkg::entry_type  push_entry;
   logic                 q_valid, q_ready;
   tlad_pkg::entry_type  q_entry;
   logic                 snap_valid, snap_ready;
   tlad_pkg::snap_type   snap;
   logic [7:0]           seg_first, seg_second, seg_third, seg_fourth;
   logic                 high_alarm, low_alarm, buzzer_pin;
   logic [1:0]           page_shown;

   tlad_front u_front (
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_mode        (req_tuser),
      .in_temperature ($signed(req_tdata[11:0])),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   tlad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   tlad_back #(
      .TICKS_PER_WRAP (TICKS_PER_WRAP),
      .BEEP_DIVIDER   (BEEP_DIVIDER)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_entry   (q_entry),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   tlad_display u_display (
      .clock          (clock),
      .reset          (reset),
      .snap_valid     (snap_valid),
      .snap_ready     (snap_ready),
      .snap           (snap),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_seg_first  (seg_first),
      .out_seg_second (seg_second),
      .out_seg_third  (seg_third),
      .out_seg_fourth (seg_fourth),
      .out_high       (high_alarm),
      .out_low        (low_alarm),
      .out_buzzer     (buzzer_pin),
      .out_page       (page_shown)
   );

   assign rsp_tdata = {5'd0, buzzer_pin, low_alarm, high_alarm,
                       seg_fourth, seg_third, seg_second, seg_first};
   assign rsp_tuser = page_shown;

   // lower limit stays below upper, so both alarms can never show together
   `TLAD_ASSERT_IMP(a_alarms_exclusive, clock, reset, rsp_tvalid, !(high_alarm && low_alarm))
   // select wraps after the lower-limit page
   `TLAD_ASSERT_IMP(a_page_range, clock, reset, rsp_tvalid, page_shown != 2'd3)
   // reset empties the pipeline
   `TLAD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && !snap_valid)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for temperature_limit_alarm_display_unit: feeds sample, key and tick events,
// tracks limits, page, alarms and buzzer locally and checks every response transfer
// depends on tlad_pkg and the unit rtl
module tb_top;

   localparam int TICKS_PER_WRAP = 100;
   localparam int BEEP_DIVIDER = 5;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST = 3'd7;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [3:0][7:0] segs;      // [0] is the leftmost digit
      logic            high;
      logic            low;
      logic            buzzer;
      logic [1:0]      page;
   } panel_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;      // [11:0] temperature, [15:12] zero
   logic [2:0]  req_tuser = tlad_pkg::MODE_SAMPLE; // [2:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] four digits, [32] high, [33] low, [34] buzzer
   logic [1:0]  rsp_tuser;          // [1:0] page shown

   // local copy of the unit state
   int         reading_tenths = 0;
   int         upper_deg = tlad_pkg::UPPER_RESET;
   int         lower_deg = tlad_pkg::LOWER_RESET;
   logic [1:0] shown_page = tlad_pkg::PAGE_TEMP;
   int         tick_count = 0;
   logic       buzzer_level = 1'b1;

   panel_type pending_panels[$];
   int     failures = 0;
   int     tx_idle_pct = 31;
   int     rx_idle_pct = 31;
   int     rx_hold_len = 0;

   temperature_limit_alarm_display_unit #(
      .TICKS_PER_WRAP(TICKS_PER_WRAP),
      .BEEP_DIVIDER(BEEP_DIVIDER)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] digit_seg(int v, bit point);
      logic [7:0] code;
      case (v % 10)
         0: code = 8'hc0;
         1: code = 8'hf9;
         2: code = 8'ha4;
         3: code = 8'hb0;
         4: code = 8'h99;
         5: code = 8'h92;
         6: code = 8'h82;
         7: code = 8'hf8;
         8: code = 8'h80;
         9: code = 8'h90;
         default: code = tlad_pkg::SEG_BLANK;
      endcase
      if (point) code[7] = 1'b0;
      return code;
   endfunction

   function automatic logic [3:0][7:0] reading_segs(int t);
      logic [3:0][7:0] s;
      int m;
      if (t >= 0) begin
         s[0] = (t > 999) ? digit_seg(t / 1000, 0) : tlad_pkg::SEG_BLANK;
         s[1] = (t > 99) ? digit_seg(t / 100, 0) : tlad_pkg::SEG_BLANK;
         s[2] = digit_seg(t / 10, 1);
         s[3] = digit_seg(t, 0);
      end else begin
         m = -t;
         // thousands of a far out negative reading are dropped
         if ((m / 100) % 10 == 0) begin
            s[0] = tlad_pkg::SEG_BLANK;
            s[1] = tlad_pkg::SEG_MINUS;
         end else begin
            s[0] = tlad_pkg::SEG_MINUS;
            s[1] = digit_seg(m / 100, 0);
         end
         s[2] = digit_seg(m / 10, 1);
         s[3] = digit_seg(m, 0);
      end
      return s;
   endfunction

   function automatic logic [3:0][7:0] limit_segs(logic [7:0] letter, int v);
      logic [3:0][7:0] s;
      s[0] = letter;
      if (v > 99) begin
         s[1] = digit_seg(v / 100, 0);
         s[2] = digit_seg(v / 10, 0);
         s[3] = digit_seg(v, 0);
      end else if (v >= 10) begin
         s[1] = tlad_pkg::SEG_BLANK;
         s[2] = digit_seg(v / 10, 0);
         s[3] = digit_seg(v, 0);
      end else if (v >= 0) begin
         s[1] = tlad_pkg::SEG_BLANK;
         s[2] = tlad_pkg::SEG_BLANK;
         s[3] = digit_seg(v, 0);
      end else if (v >= -9) begin
         s[1] = tlad_pkg::SEG_BLANK;
         s[2] = tlad_pkg::SEG_MINUS;
         s[3] = digit_seg(-v, 0);
      end else begin
         s[1] = tlad_pkg::SEG_MINUS;
         s[2] = digit_seg(-v / 10, 0);
         s[3] = digit_seg(-v, 0);
      end
      return s;
   endfunction

   // updates the local state for one event and returns the panel it leaves behind
   function automatic panel_type apply_event(logic [2:0] mode, int temp);
      panel_type p;
      logic signed [11:0] raw;
      bit hi;
      bit lo;
      raw = temp[11:0];
      case (mode)
         tlad_pkg::MODE_SAMPLE: reading_tenths = raw;
         tlad_pkg::MODE_UP: begin
            if (shown_page == tlad_pkg::PAGE_UPPER) begin
               if (upper_deg < tlad_pkg::UPPER_MAX) upper_deg++;
            end else if (shown_page == tlad_pkg::PAGE_LOWER) begin
               if (lower_deg < upper_deg - 1) lower_deg++;
            end
         end
         tlad_pkg::MODE_DOWN: begin
            if (shown_page == tlad_pkg::PAGE_UPPER) begin
               if (upper_deg > lower_deg + 1) upper_deg--;
            end else if (shown_page == tlad_pkg::PAGE_LOWER) begin
               if (lower_deg > tlad_pkg::LOWER_MIN) lower_deg--;
            end
         end
         tlad_pkg::MODE_SELECT: begin
            shown_page = (shown_page == tlad_pkg::PAGE_LOWER) ? tlad_pkg::PAGE_TEMP
                                                              : shown_page + 2'd1;
         end
         tlad_pkg::MODE_TICK: begin
            tick_count++;
            if (tick_count > TICKS_PER_WRAP) tick_count = 0;
            if (tick_count % BEEP_DIVIDER == 0) begin
               if (reading_tenths / 10 >= upper_deg || reading_tenths / 10 <= lower_deg)
                  buzzer_level = ~buzzer_level;
               else
                  buzzer_level = 1'b1;
            end
         end
         default: ;
      endcase
      hi = (reading_tenths / 10 >= upper_deg);
      lo = (reading_tenths / 10 <= lower_deg);
      if (shown_page == tlad_pkg::PAGE_UPPER)
         p.segs = limit_segs(tlad_pkg::SEG_H, upper_deg);
      else if (shown_page == tlad_pkg::PAGE_LOWER)
         p.segs = limit_segs(tlad_pkg::SEG_L, lower_deg);
      else
         p.segs = reading_segs(reading_tenths);
      p.high = hi;
      p.low = lo;
      p.buzzer = buzzer_level;
      p.page = shown_page;
      return p;
   endfunction

   function automatic void note_failure(string what, longint want, longint got);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("mismatch %s: expected %0h actual %0h", what, want, got);
   endfunction

   // mostly in sensor range, some around the limits, a few over the whole field
   function automatic int pick_temperature();
      int r;
      int lim;
      r = $urandom_range(99);
      if (r < 10) return int'($urandom_range(4095)) - 2048;
      if (r < 35) begin
         lim = $urandom_range(1) ? upper_deg : lower_deg;
         return lim * 10 + int'($urandom_range(50)) - 25;
      end
      return int'($urandom_range(1800)) - 550;
   endfunction

   task automatic send_event(input logic [2:0] mode, input int temp);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {4'd0, temp[11:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_panels.push_back(apply_event(mode, temp));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_panels.size() != 0) @(posedge clock);
   endtask

   task automatic send_repeated(input logic [2:0] mode, input int count);
      for (int i = 0; i < count; i++) send_event(mode, pick_temperature());
   endtask

   task automatic test_directed_cases();
      send_event(tlad_pkg::MODE_SAMPLE, 0);
      send_event(tlad_pkg::MODE_SAMPLE, 99);      // 9.9 shown as two blanks then 9. 9
      send_event(tlad_pkg::MODE_SAMPLE, 100);
      send_event(tlad_pkg::MODE_SAMPLE, 999);
      send_event(tlad_pkg::MODE_SAMPLE, 1000);
      send_event(tlad_pkg::MODE_SAMPLE, 1250);
      send_event(tlad_pkg::MODE_SAMPLE, 2047);
      send_event(tlad_pkg::MODE_SAMPLE, -2048);
      send_event(tlad_pkg::MODE_SAMPLE, -550);
      send_event(tlad_pkg::MODE_SAMPLE, -5);
      send_event(tlad_pkg::MODE_SAMPLE, -99);
      send_event(tlad_pkg::MODE_SAMPLE, -100);
      send_event(tlad_pkg::MODE_SAMPLE, 355);
      // keys on the temperature page change nothing
      send_event(tlad_pkg::MODE_UP, 0);
      send_event(tlad_pkg::MODE_DOWN, 0);
      send_event(tlad_pkg::MODE_TICK, 0);
      send_event(MODE_SPARE_FIRST, 4095);
      send_event(MODE_SPARE_LAST, 1234);
      send_event(tlad_pkg::MODE_SELECT, 0);
      send_event(tlad_pkg::MODE_UP, 0);
      send_event(tlad_pkg::MODE_DOWN, 0);
      send_event(tlad_pkg::MODE_SELECT, 0);
      send_event(tlad_pkg::MODE_DOWN, 0);
      send_event(tlad_pkg::MODE_UP, 0);
      send_event(tlad_pkg::MODE_SELECT, 0);
      send_event(tlad_pkg::MODE_SAMPLE, 160);
   endtask

   task automatic test_alarm_and_buzzer();
      send_event(tlad_pkg::MODE_SAMPLE, 367);
      send_repeated(tlad_pkg::MODE_TICK, 120);    // passes the tick wrap
      send_event(tlad_pkg::MODE_SAMPLE, 350);
      send_event(tlad_pkg::MODE_SAMPLE, 349);
      send_repeated(tlad_pkg::MODE_TICK, 10);
      send_event(tlad_pkg::MODE_SAMPLE, 169);
      send_repeated(tlad_pkg::MODE_TICK, 30);
      send_event(tlad_pkg::MODE_SAMPLE, -37);     // whole degrees truncate toward zero
      send_repeated(tlad_pkg::MODE_TICK, 10);
      send_event(tlad_pkg::MODE_SAMPLE, 250);
      send_repeated(tlad_pkg::MODE_TICK, 12);
   endtask

   // walks both limits into their caps and against each other
   task automatic test_limit_travel();
      while (shown_page != tlad_pkg::PAGE_UPPER) send_event(tlad_pkg::MODE_SELECT, 0);
      send_repeated(tlad_pkg::MODE_UP, 100);
      send_repeated(tlad_pkg::MODE_DOWN, 130);
      send_repeated(tlad_pkg::MODE_UP, 5);
      send_event(tlad_pkg::MODE_SELECT, 0);
      send_repeated(tlad_pkg::MODE_UP, 120);
      send_repeated(tlad_pkg::MODE_DOWN, 90);
      send_event(tlad_pkg::MODE_SELECT, 0);
      send_event(tlad_pkg::MODE_SELECT, 0);
      send_repeated(tlad_pkg::MODE_DOWN, 100);
      send_repeated(tlad_pkg::MODE_UP, 60);
      while (shown_page != tlad_pkg::PAGE_TEMP) send_event(tlad_pkg::MODE_SELECT, 0);
   endtask

   task automatic test_output_backpressure();
      tx_idle_pct = 0;
      rx_hold_len = 300;
      for (int i = 0; i < 40; i++)
         send_event(3'($urandom_range(tlad_pkg::MODE_TICK)), pick_temperature());
      wait_for_drain();
      tx_idle_pct = 31;
   endtask

   task automatic test_random_events(input int count);
      int r;
      logic [2:0] mode;
      for (int i = 0; i < count; i++) begin
         // a stretch with no idling on either side
         if (i == count / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (i == count / 2) begin
            tx_idle_pct = 31;
            rx_idle_pct = 31;
         end
         r = $urandom_range(99);
         if (r < 30) mode = tlad_pkg::MODE_SAMPLE;
         else if (r < 45) mode = tlad_pkg::MODE_UP;
         else if (r < 60) mode = tlad_pkg::MODE_DOWN;
         else if (r < 70) mode = tlad_pkg::MODE_SELECT;
         else if (r < 97) mode = tlad_pkg::MODE_TICK;
         else mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
         send_event(mode, pick_temperature());
      end
   endtask

   // response side, counts its own hold-off cycles
   initial begin : response_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_len != 0) begin
            hold_left = rx_hold_len;
            rx_hold_len = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_response
      panel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_panels.size() == 0) begin
            note_failure("unexpected transfer", 0, rsp_tdata);
         end else begin
            want = pending_panels.pop_front();
            for (int i = 0; i < 4; i++)
               if (rsp_tdata[8*i +: 8] !== want.segs[i])
                  note_failure($sformatf("digit %0d", i), want.segs[i], rsp_tdata[8*i +: 8]);
            if (rsp_tdata[32] !== want.high) note_failure("high_alarm", want.high, rsp_tdata[32]);
            if (rsp_tdata[33] !== want.low) note_failure("low_alarm", want.low, rsp_tdata[33]);
            if (rsp_tdata[34] !== want.buzzer)
               note_failure("buzzer_pin", want.buzzer, rsp_tdata[34]);
            if (rsp_tuser !== want.page) note_failure("page_shown", want.page, rsp_tuser);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_alarm_and_buzzer();
      test_limit_travel();
      test_output_backpressure();
      test_random_events(900);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      failures += pending_panels.size();
      if (failures == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
